/* design/sgr_pkg.sv */
// ----------------------------------------------------------------------------
// Sequence gap range table: shared definitions
// Status codes, field widths and the compare result type used by the table.
// ----------------------------------------------------------------------------
`default_nettype none

package sgr_pkg;

    localparam int SPAN_W   = 32;
    localparam int FIELD_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int TDATA_W  = 72;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVL_BELOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVL_ABOVE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd7;

    // Serial comparison of a against b.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

`default_nettype wire

/* design/sgr_cmp.sv */
// ----------------------------------------------------------------------------
// Sequence gap range table: serial comparator
// Wrap-aware comparison of two sequence numbers by one subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_cmp #(
    parameter int SEQ_BITS = 32
) (
    input  wire logic [SEQ_BITS-1:0] a,
    input  wire logic [SEQ_BITS-1:0] b,
    output sgr_pkg::cmp_t            res
);
    import sgr_pkg::*;

    logic [SEQ_BITS-1:0] diff;

    // a is below b when the top bit of the difference is set.
    always_comb begin
        diff   = a - b;
        res.lt = diff[SEQ_BITS-1];
        res.eq = (diff == '0);
    end

endmodule

`default_nettype wire

/* design/sgr_mem.sv */
// ----------------------------------------------------------------------------
// Sequence gap range table: entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data_reg
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/sequence_gap_range_table.sv */
// ----------------------------------------------------------------------------
// Sequence gap range table
// Ordered table of disjoint missing sequence ranges with add, remove and
// extract-lowest operations, run by a sequencer around one comparator.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         operation, start_number, span
//  m_axis    out        status, popped_start, popped_span
//  cfg       in         extent_limit write
//
//  The search reads each of the N stored ranges in turn, and each entry
//  moved takes a read and then a write, as the entry memory has one
//  registered read port. A wrapped add runs the insert twice,
//  and a remove that splits a range runs a second search for its tail.
//  aresetn clears the range count, the output valid and the sequencer, and sets the limit to 65535.
//  The block takes no item while one is in progress; a waiting result is
//  held in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_gap_range_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int SEQ_BITS      = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wen,
    input  wire logic [sgr_pkg::FIELD_W-1:0]    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // operation[1:0], start_number[33:2], span[65:34], zero fill
    input  wire logic [sgr_pkg::TDATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[2:0], popped_start[34:3], popped_span[66:35], zero fill
    output logic      [sgr_pkg::TDATA_W-1:0]    m_tdata
);
    import sgr_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = SEQ_BITS + SPAN_W;
    localparam logic [SEQ_BITS-1:0] SEQ_MASK = {SEQ_BITS{1'b1}};

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ADD_CHK = 5'd1;
    localparam logic [4:0] S_SCAN_RD = 5'd2;
    localparam logic [4:0] S_SCAN_EV = 5'd3;
    localparam logic [4:0] S_INS_B   = 5'd4;
    localparam logic [4:0] S_INS_C   = 5'd5;
    localparam logic [4:0] S_INS_D   = 5'd6;
    localparam logic [4:0] S_SH_RD   = 5'd7;
    localparam logic [4:0] S_SH_WR   = 5'd8;
    localparam logic [4:0] S_INS_WR  = 5'd9;
    localparam logic [4:0] S_REM_A   = 5'd10;
    localparam logic [4:0] S_REM_B   = 5'd11;
    localparam logic [4:0] S_DEL_RD  = 5'd12;
    localparam logic [4:0] S_DEL_WR  = 5'd13;
    localparam logic [4:0] S_EXT_RD  = 5'd14;
    localparam logic [4:0] S_EXT_EV  = 5'd15;
    localparam logic [4:0] S_DONE    = 5'd16;

    logic [4:0]          state_reg, state_next;
    logic [FIELD_W-1:0]  limit_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [SEQ_BITS-1:0] key_reg, key_next;
    logic [SPAN_W-1:0]   ext_reg, ext_next;
    logic [SPAN_W-1:0]   ins_e_reg, ins_e_next;
    logic                split_reg, split_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       j_reg, j_next;
    logic                bfound_reg, bfound_next;
    logic [AW-1:0]       bidx_reg, bidx_next;
    logic [SEQ_BITS-1:0] bs_reg, bs_next;
    logic [SPAN_W-1:0]   bspan_reg, bspan_next;
    logic                afound_reg, afound_next;
    logic [SEQ_BITS-1:0] as_reg, as_next;
    logic                pfound_reg, pfound_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic                rlt_reg, rlt_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FIELD_W-1:0]  pops_reg, pops_next;
    logic [SPAN_W-1:0]   pope_reg, pope_next;
    logic                mvalid_reg;
    logic [TDATA_W-1:0]  mdata_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [EW-1:0]       mem_wdata, mem_rdata;
    logic [SEQ_BITS-1:0] rd_start;
    logic [SPAN_W-1:0]   rd_span;
    logic [SEQ_BITS-1:0] cmp_a, cmp_b;
    cmp_t                cmp_res;
    logic [SEQ_BITS-1:0] end_b;
    logic [SEQ_BITS:0]   wrap_sum;
    logic [SEQ_BITS-1:0] lower;
    logic                last_scan;

    sgr_mem #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (EW)
    ) u_mem (
        .aclk        (aclk),
        .wr_en       (mem_we),
        .wr_addr     (mem_waddr),
        .wr_data     (mem_wdata),
        .rd_addr     (mem_raddr),
        .rd_data_reg (mem_rdata)
    );

    sgr_cmp #(
        .SEQ_BITS (SEQ_BITS)
    ) u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // Entry layout: span above start.
    assign rd_start = mem_rdata[SEQ_BITS-1:0];
    assign rd_span  = mem_rdata[EW-1:SEQ_BITS];
    assign end_b    = bs_reg + bspan_reg[SEQ_BITS-1:0];
    assign wrap_sum = {1'b0, key_reg} + {1'b0, ext_reg[SEQ_BITS-1:0]};
    assign lower    = SEQ_MASK - key_reg;
    assign last_scan = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // Comparator operands follow the sequencer step.
    always_comb begin
        cmp_a = rd_start;
        cmp_b = key_reg;
        unique case (state_reg)
            S_INS_C: begin
                cmp_a = key_reg;
                cmp_b = end_b;
            end
            S_INS_D: begin
                cmp_a = key_reg + ins_e_reg[SEQ_BITS-1:0];
                cmp_b = as_reg;
            end
            S_REM_A: begin
                cmp_a = key_reg;
                cmp_b = end_b;
            end
            S_REM_B: begin
                cmp_a = key_reg;
                cmp_b = bs_reg;
            end
            default: begin
                cmp_a = rd_start;
                cmp_b = key_reg;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        ext_next    = ext_reg;
        ins_e_next  = ins_e_reg;
        split_next  = split_reg;
        idx_next    = idx_reg;
        j_next      = j_reg;
        bfound_next = bfound_reg;
        bidx_next   = bidx_reg;
        bs_next     = bs_reg;
        bspan_next  = bspan_reg;
        afound_next = afound_reg;
        as_next     = as_reg;
        pfound_next = pfound_reg;
        pos_next    = pos_reg;
        rlt_next    = rlt_reg;
        status_next = status_reg;
        pops_next   = pops_reg;
        pope_next   = pope_reg;
        mem_we      = 1'b0;
        mem_waddr   = j_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tdata[OP_W-1:0];
                    key_next    = s_tdata[OP_W +: SEQ_BITS];
                    ext_next    = s_tdata[OP_W+FIELD_W +: SPAN_W];
                    pops_next   = '0;
                    pope_next   = '0;
                    idx_next    = '0;
                    bfound_next = 1'b0;
                    afound_next = 1'b0;
                    pfound_next = 1'b0;
                    unique case (s_tdata[OP_W-1:0])
                        OP_ADD:     state_next = S_ADD_CHK;
                        OP_REMOVE:  state_next = (count_reg == '0) ? S_REM_A : S_SCAN_RD;
                        OP_EXTRACT: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_EXT_RD;
                            end
                        end
                        default: begin
                            status_next = ST_INVALID;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            // Limit, capacity and wrap checks for one add pass.
            S_ADD_CHK: begin
                idx_next    = '0;
                bfound_next = 1'b0;
                afound_next = 1'b0;
                pfound_next = 1'b0;
                if (ext_reg > limit_reg) begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end else if (count_reg >= CW'(TABLE_ENTRIES)) begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    if ((ext_reg > SPAN_W'(SEQ_MASK)) || wrap_sum[SEQ_BITS]) begin
                        ins_e_next = SPAN_W'(lower);
                        split_next = 1'b1;
                    end else begin
                        ins_e_next = ext_reg;
                        split_next = 1'b0;
                    end
                    state_next = (count_reg == '0) ? S_INS_B : S_SCAN_RD;
                end
            end

            // Linear search over the stored entries.
            S_SCAN_RD: begin
                mem_raddr  = idx_reg;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (cmp_res.lt || cmp_res.eq) begin
                    bfound_next = 1'b1;
                    bidx_next   = idx_reg;
                    bs_next     = rd_start;
                    bspan_next  = rd_span;
                end
                if (!cmp_res.lt && !afound_reg) begin
                    afound_next = 1'b1;
                    as_next     = rd_start;
                end
                if (!cmp_res.lt && !cmp_res.eq && !pfound_reg) begin
                    pfound_next = 1'b1;
                    pos_next    = idx_reg;
                end
                idx_next = idx_reg + AW'(1);
                if (last_scan) begin
                    state_next = (op_reg == OP_ADD) ? S_INS_B : S_REM_A;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end

            // Insert checks against the neighbours.
            S_INS_B: begin
                if (!pfound_reg) begin
                    pos_next = count_reg[AW-1:0];
                end
                j_next = count_reg[AW-1:0];
                if (bfound_reg && (bs_reg == key_reg)) begin
                    status_next = ST_DUPLICATE;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_INS_C;
                end
            end
            S_INS_C: begin
                if (bfound_reg && (cmp_res.lt || cmp_res.eq)) begin
                    status_next = ST_OVL_BELOW;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_INS_D;
                end
            end
            S_INS_D: begin
                if (afound_reg && !cmp_res.lt) begin
                    status_next = ST_OVL_ABOVE;
                    state_next  = S_DONE;
                end else begin
                    state_next = (j_reg == pos_reg) ? S_INS_WR : S_SH_RD;
                end
            end

            // Open a gap at the insert position.
            S_SH_RD: begin
                mem_raddr  = j_reg - AW'(1);
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = j_reg;
                mem_wdata  = mem_rdata;
                j_next     = j_reg - AW'(1);
                state_next = ((j_reg - AW'(1)) == pos_reg) ? S_INS_WR : S_SH_RD;
            end
            S_INS_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = {ins_e_reg, key_reg};
                count_next = count_reg + CW'(1);
                if (split_reg) begin
                    ext_next   = ext_reg - SPAN_W'(lower) - SPAN_W'(1);
                    key_next   = '0;
                    state_next = S_ADD_CHK;
                end else begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end

            // Remove: the number must lie inside the range below it.
            S_REM_A: begin
                rlt_next = cmp_res.lt;
                if (!bfound_reg || !(cmp_res.lt || cmp_res.eq)) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_REM_B;
                end
            end
            S_REM_B: begin
                j_next = bidx_reg;
                if (cmp_res.eq) begin
                    if (bspan_reg != '0) begin
                        mem_we      = 1'b1;
                        mem_waddr   = bidx_reg;
                        mem_wdata   = {bspan_reg - SPAN_W'(1), bs_reg + SEQ_BITS'(1)};
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end else if ((CW'(bidx_reg) + CW'(1)) < count_reg) begin
                        state_next = S_DEL_RD;
                    end else begin
                        count_next  = count_reg - CW'(1);
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                end else begin
                    // Trim to the head part; any tail goes back in as an add.
                    mem_we    = 1'b1;
                    mem_waddr = bidx_reg;
                    mem_wdata = {SPAN_W'(key_reg - bs_reg - SEQ_BITS'(1)), bs_reg};
                    if (rlt_reg) begin
                        op_next    = OP_ADD;
                        key_next   = key_reg + SEQ_BITS'(1);
                        ext_next   = SPAN_W'(end_b - key_reg - SEQ_BITS'(1));
                        state_next = S_ADD_CHK;
                    end else begin
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                end
            end

            // Close the hole left by a deleted entry.
            S_DEL_RD: begin
                mem_raddr  = j_reg + AW'(1);
                state_next = S_DEL_WR;
            end
            S_DEL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = mem_rdata;
                j_next    = j_reg + AW'(1);
                if ((CW'(j_reg) + CW'(2)) < count_reg) begin
                    state_next = S_DEL_RD;
                end else begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end

            // Extract the first entry.
            S_EXT_RD: begin
                mem_raddr  = '0;
                state_next = S_EXT_EV;
            end
            S_EXT_EV: begin
                pops_next = FIELD_W'(rd_start);
                pope_next = rd_span;
                j_next    = '0;
                if (count_reg > CW'(1)) begin
                    state_next = S_DEL_RD;
                end else begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            limit_reg  <= FIELD_W'(65535);
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
            if (state_reg == S_DONE && (!mvalid_reg || m_tready)) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        ext_reg    <= ext_next;
        ins_e_reg  <= ins_e_next;
        split_reg  <= split_next;
        idx_reg    <= idx_next;
        j_reg      <= j_next;
        bfound_reg <= bfound_next;
        bidx_reg   <= bidx_next;
        bs_reg     <= bs_next;
        bspan_reg  <= bspan_next;
        afound_reg <= afound_next;
        as_reg     <= as_next;
        pfound_reg <= pfound_next;
        pos_reg    <= pos_next;
        rlt_reg    <= rlt_next;
        status_reg <= status_next;
        pops_reg   <= pops_next;
        pope_reg   <= pope_next;
        if (state_reg == S_DONE && (!mvalid_reg || m_tready)) begin
            mdata_reg <= {{(TDATA_W-STATUS_W-FIELD_W-SPAN_W){1'b0}},
                          pope_reg, pops_reg, status_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

`ifndef ASSERT_OFF
    // The range count never passes the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("range count above table size");

    // After a transfer in, no further item is taken in the next cycle.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted during work");

    // The count changes by at most one per cycle.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg == $past(count_reg) - CW'(1))))
        else $error("range count jumped");
`endif

endmodule

`default_nettype wire
